// ===== src/ufad_pkg.sv =====
// Package for the UBX frame and acknowledgement detector: codes, constants and shared types.
package ufad_pkg;

  localparam int unsigned LEN_W = 10;
  localparam int unsigned MAX_PAYLOAD = 1016;

  localparam logic [7:0] SYNC_A     = 8'hB5;
  localparam logic [7:0] SYNC_B     = 8'h62;
  localparam logic [7:0] ACK_CLASS  = 8'h05;
  localparam logic [7:0] ACK_ACK_ID = 8'h01;
  localparam logic [7:0] ACK_NAK_ID = 8'h00;

  localparam logic [1:0] REQ_BYTE  = 2'd0;
  localparam logic [1:0] REQ_TICK  = 2'd1;
  localparam logic [1:0] REQ_WAIT  = 2'd2;

  localparam logic [1:0] VERDICT_NONE    = 2'd0;
  localparam logic [1:0] VERDICT_ACK     = 2'd1;
  localparam logic [1:0] VERDICT_NAK     = 2'd2;
  localparam logic [1:0] VERDICT_TIMEOUT = 2'd3;

  localparam logic [1:0] CFG_WANT_CLASS = 2'd0;
  localparam logic [1:0] CFG_WANT_ID    = 2'd1;
  localparam logic [1:0] CFG_TIMEOUT    = 2'd2;

  localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

  localparam logic [3:0] PH_HUNT1   = 4'd0;
  localparam logic [3:0] PH_HUNT2   = 4'd1;
  localparam logic [3:0] PH_CLASS   = 4'd2;
  localparam logic [3:0] PH_ID      = 4'd3;
  localparam logic [3:0] PH_LEN_LO  = 4'd4;
  localparam logic [3:0] PH_LEN_HI  = 4'd5;
  localparam logic [3:0] PH_PAYLOAD = 4'd6;
  localparam logic [3:0] PH_CK_A    = 4'd7;
  localparam logic [3:0] PH_CK_B    = 4'd8;

  typedef struct packed {
    logic             done;
    logic [7:0]       cls;
    logic [7:0]       id;
    logic [LEN_W-1:0] len;
    logic [7:0]       p0;
    logic [7:0]       p1;
  } frame_info_t;

  typedef struct packed {
    logic             frame_done;
    logic [7:0]       done_class;
    logic [7:0]       done_id;
    logic [LEN_W-1:0] done_length;
    logic [1:0]       verdict;
    logic             busy_waiting;
  } result_t;

endpackage

// ===== src/ufad_ifs.sv =====
// Channel interfaces: request input, result output and register write port.
interface ufad_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] rx_byte;
  modport source (output valid, req_type, rx_byte, input ready);
  modport sink (input valid, req_type, rx_byte, output ready);
endinterface

interface ufad_out_if;
  logic                        valid;
  logic                        ready;
  logic                        frame_done;
  logic [7:0]                  done_class;
  logic [7:0]                  done_id;
  logic [ufad_pkg::LEN_W-1:0]  done_length;
  logic [1:0]                  verdict;
  logic                        busy_waiting;
  modport source (output valid, frame_done, done_class, done_id, done_length, verdict,
                  busy_waiting, input ready);
  modport sink (input valid, frame_done, done_class, done_id, done_length, verdict,
                busy_waiting, output ready);
endinterface

interface ufad_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  reg_index;
  logic [15:0] wdata;
  modport source (output valid, reg_index, wdata, input ready);
  modport sink (input valid, reg_index, wdata, output ready);
endinterface

// ===== src/ufad_parser.sv =====
// Byte-wise UBX frame parser: sync hunt, header, length, payload capture and checksum skip.
module ufad_parser (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step,
  input  logic [7:0]            rx_byte,
  output ufad_pkg::frame_info_t info
);

  logic [3:0]                 phase_r, phase_nxt;
  logic [7:0]                 cls_r, cls_nxt;
  logic [7:0]                 id_r, id_nxt;
  logic [7:0]                 len_lo_r, len_lo_nxt;
  logic [ufad_pkg::LEN_W-1:0] len_r, len_nxt;
  logic [ufad_pkg::LEN_W-1:0] count_r, count_nxt;
  logic [7:0]                 p0_r, p0_nxt;
  logic [7:0]                 p1_r, p1_nxt;
  logic [15:0]                full_len;
  logic                       done;

  assign full_len = {rx_byte, len_lo_r};

  always_comb begin
    phase_nxt  = phase_r;
    cls_nxt    = cls_r;
    id_nxt     = id_r;
    len_lo_nxt = len_lo_r;
    len_nxt    = len_r;
    count_nxt  = count_r;
    p0_nxt     = p0_r;
    p1_nxt     = p1_r;
    done       = 1'b0;
    unique case (phase_r)
      ufad_pkg::PH_HUNT1: begin
        if (rx_byte == ufad_pkg::SYNC_A) phase_nxt = ufad_pkg::PH_HUNT2;
      end
      ufad_pkg::PH_HUNT2: begin
        // A repeated first sync byte keeps the hunt armed for the second.
        if (rx_byte == ufad_pkg::SYNC_B) phase_nxt = ufad_pkg::PH_CLASS;
        else if (rx_byte != ufad_pkg::SYNC_A) phase_nxt = ufad_pkg::PH_HUNT1;
      end
      ufad_pkg::PH_CLASS: begin
        cls_nxt   = rx_byte;
        phase_nxt = ufad_pkg::PH_ID;
      end
      ufad_pkg::PH_ID: begin
        id_nxt    = rx_byte;
        phase_nxt = ufad_pkg::PH_LEN_LO;
      end
      ufad_pkg::PH_LEN_LO: begin
        len_lo_nxt = rx_byte;
        phase_nxt  = ufad_pkg::PH_LEN_HI;
      end
      ufad_pkg::PH_LEN_HI: begin
        // Only lengths up to the maximum are kept, so the stored length is narrow.
        len_nxt   = full_len[ufad_pkg::LEN_W-1:0];
        count_nxt = '0;
        p0_nxt    = '0;
        p1_nxt    = '0;
        if (full_len > 16'(ufad_pkg::MAX_PAYLOAD)) phase_nxt = ufad_pkg::PH_HUNT1;
        else if (full_len == 16'd0) phase_nxt = ufad_pkg::PH_CK_A;
        else phase_nxt = ufad_pkg::PH_PAYLOAD;
      end
      ufad_pkg::PH_PAYLOAD: begin
        if (count_r == '0) p0_nxt = rx_byte;
        else if (count_r == ufad_pkg::LEN_W'(1)) p1_nxt = rx_byte;
        count_nxt = count_r + ufad_pkg::LEN_W'(1);
        if (count_nxt >= len_r) phase_nxt = ufad_pkg::PH_CK_A;
      end
      ufad_pkg::PH_CK_A: begin
        phase_nxt = ufad_pkg::PH_CK_B;
      end
      ufad_pkg::PH_CK_B: begin
        phase_nxt = ufad_pkg::PH_HUNT1;
        done      = 1'b1;
      end
      default: begin
        phase_nxt = ufad_pkg::PH_HUNT1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= ufad_pkg::PH_HUNT1;
      cls_r    <= '0;
      id_r     <= '0;
      len_lo_r <= '0;
      len_r    <= '0;
      count_r  <= '0;
      p0_r     <= '0;
      p1_r     <= '0;
    end else if (step) begin
      phase_r  <= phase_nxt;
      cls_r    <= cls_nxt;
      id_r     <= id_nxt;
      len_lo_r <= len_lo_nxt;
      len_r    <= len_nxt;
      count_r  <= count_nxt;
      p0_r     <= p0_nxt;
      p1_r     <= p1_nxt;
    end
  end

  assign info.done = done;
  assign info.cls  = cls_r;
  assign info.id   = id_r;
  assign info.len  = len_r;
  assign info.p0   = p0_r;
  assign info.p1   = p1_r;

endmodule

// ===== src/ufad_waiter.sv =====
// Acknowledgement wait: configuration registers, tick counter and result assembly.
module ufad_waiter (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step,
  input  logic [1:0]            req_type,
  input  ufad_pkg::frame_info_t info,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_idx,
  input  logic [15:0]           cfg_data,
  output ufad_pkg::result_t     res
);

  logic [7:0]  want_class_r;
  logic [7:0]  want_id_r;
  logic [15:0] timeout_r;
  logic        wait_r, wait_nxt;
  logic [15:0] elapsed_r, elapsed_nxt;
  logic [15:0] elapsed_inc;
  logic        frame_done;
  logic        ack_hit;
  logic [1:0]  verdict;

  assign frame_done  = (req_type == ufad_pkg::REQ_BYTE) && info.done;
  assign elapsed_inc = (elapsed_r == 16'hFFFF) ? elapsed_r : elapsed_r + 16'd1;

  // An acknowledgement counts only if it carries at least the class and id it names.
  assign ack_hit = wait_r && frame_done && (info.cls == ufad_pkg::ACK_CLASS) &&
                   ((info.id == ufad_pkg::ACK_ACK_ID) || (info.id == ufad_pkg::ACK_NAK_ID)) &&
                   (info.len >= ufad_pkg::LEN_W'(2)) &&
                   (info.p0 == want_class_r) && (info.p1 == want_id_r);

  always_comb begin
    wait_nxt    = wait_r;
    elapsed_nxt = elapsed_r;
    verdict     = ufad_pkg::VERDICT_NONE;
    unique case (req_type)
      ufad_pkg::REQ_BYTE: begin
        if (ack_hit) begin
          verdict  = (info.id == ufad_pkg::ACK_ACK_ID) ? ufad_pkg::VERDICT_ACK
                                                        : ufad_pkg::VERDICT_NAK;
          wait_nxt = 1'b0;
        end
      end
      ufad_pkg::REQ_TICK: begin
        if (wait_r) begin
          elapsed_nxt = elapsed_inc;
          if (elapsed_inc >= timeout_r) begin
            verdict  = ufad_pkg::VERDICT_TIMEOUT;
            wait_nxt = 1'b0;
          end
        end
      end
      ufad_pkg::REQ_WAIT: begin
        elapsed_nxt = '0;
        if (timeout_r == 16'd0) begin
          verdict  = ufad_pkg::VERDICT_TIMEOUT;
          wait_nxt = 1'b0;
        end else begin
          wait_nxt = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      want_class_r <= '0;
      want_id_r    <= '0;
      timeout_r    <= ufad_pkg::TIMEOUT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        ufad_pkg::CFG_WANT_CLASS: want_class_r <= cfg_data[7:0];
        ufad_pkg::CFG_WANT_ID:    want_id_r    <= cfg_data[7:0];
        ufad_pkg::CFG_TIMEOUT:    timeout_r    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wait_r    <= 1'b0;
      elapsed_r <= '0;
    end else if (step) begin
      wait_r    <= wait_nxt;
      elapsed_r <= elapsed_nxt;
    end
  end

  assign res.frame_done   = frame_done;
  assign res.done_class   = frame_done ? info.cls : 8'd0;
  assign res.done_id      = frame_done ? info.id : 8'd0;
  assign res.done_length  = frame_done ? info.len : '0;
  assign res.verdict      = verdict;
  assign res.busy_waiting = wait_nxt;

endmodule

// ===== src/ubx_frame_ack_detector_core.sv =====
// Top level of the UBX frame and acknowledgement detector.
// Each request is captured in an input register; its result is then taken into an output register
// once that register is empty or its result is being accepted, and is offered from there.
// Throughput is one request per cycle unless the output stalls; the parser phase and wait state update in one step.
// Reset (rst_n, synchronous, active low) empties both registers, returns the parser to the
// sync hunt, ends any wait and restores the registers to class 0, id 0 and 1000 ticks.
module ubx_frame_ack_detector_core (
  input  logic        clk,
  input  logic        rst_n,
  ufad_in_if.sink     in_chan,
  ufad_out_if.source  out_chan,
  ufad_cfg_if.sink    cfg_chan
);

  logic              in_valid_r;
  logic [1:0]        in_req_r;
  logic [7:0]        in_byte_r;
  logic              out_valid_r;
  ufad_pkg::result_t out_res_r;
  logic              advance;
  logic              in_take;
  ufad_pkg::frame_info_t info;
  ufad_pkg::result_t res;

  assign advance = in_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = !in_valid_r || advance;
  assign in_take = in_chan.valid && in_chan.ready;
  assign cfg_chan.ready = 1'b1;

  ufad_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (advance && (in_req_r == ufad_pkg::REQ_BYTE)),
    .rx_byte (in_byte_r),
    .info    (info)
  );

  ufad_waiter u_waiter (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (advance),
    .req_type (in_req_r),
    .info     (info),
    .cfg_we   (cfg_chan.valid),
    .cfg_idx  (cfg_chan.reg_index),
    .cfg_data (cfg_chan.wdata),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      in_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_req_r  <= in_chan.req_type;
      in_byte_r <= in_chan.rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= res;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.frame_done   = out_res_r.frame_done;
  assign out_chan.done_class   = out_res_r.done_class;
  assign out_chan.done_id      = out_res_r.done_id;
  assign out_chan.done_length  = out_res_r.done_length;
  assign out_chan.verdict      = out_res_r.verdict;
  assign out_chan.busy_waiting = out_res_r.busy_waiting;

endmodule
